// ===== src/lcgrs_pkg.sv =====
package lcgrs_pkg;

  // Generator arithmetic.
  localparam int unsigned STATE_W = 32;
  localparam logic [STATE_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [STATE_W-1:0] LCG_INC = 32'd12345;

  // The draw takes 15 bits starting at bit 16 of the new state.
  localparam int unsigned DRAW_LSB = 16;
  localparam int unsigned DRAW_W = 15;

  // Beat field widths.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned BYTE_W = 8;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_SEED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHUF = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUICK = 2'd3;

  // Control toward the shared arithmetic unit.
  typedef struct packed {
    logic start;
    logic seed_op;
  } unit_req_t;

  // Status from the shared arithmetic unit.
  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

// ===== src/lcgrs_ram.sv =====
module lcgrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lcgrs_draw.sv =====
module lcgrs_draw
  import lcgrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  unit_req_t           req,
  input  logic [STATE_W-1:0]  operand,
  input  logic [VALUE_W-1:0]  bound,
  output unit_rsp_t           rsp,
  output logic [STATE_W-1:0]  state_out,
  output logic [VALUE_W-1:0]  rem_out
);

  localparam int unsigned CNT_W = $clog2(DRAW_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRAW_W - 1);

  logic                 div_act_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [STATE_W-1:0]   st_r;
  logic [DRAW_W-1:0]    sh_r;
  logic [VALUE_W:0]     rem_r;
  logic [VALUE_W:0]     dvs_r;

  logic [STATE_W-1:0]   prod;
  logic [VALUE_W+1:0]   rem_try;
  logic [VALUE_W+1:0]   rem_sub;
  logic                 take;
  logic [VALUE_W:0]     rem_nxt;

  // One generator step: multiply by the constant and add the increment, modulo 2^32.
  assign prod = operand * LCG_MUL + LCG_INC;

  // One restoring-division step: bring in the next draw bit and subtract if it fits.
  assign rem_try = {rem_r, sh_r[DRAW_W-1]};
  assign rem_sub = rem_try - {1'b0, dvs_r};
  assign take    = rem_try >= {1'b0, dvs_r};
  assign rem_nxt = take ? rem_sub[VALUE_W:0] : rem_try[VALUE_W:0];

  // Sequencer of the shared unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // A seed finishes at once; a draw then runs one quotient bit per cycle.
        st_r      <= (req.seed_op && prod == '0) ? STATE_W'(1) : prod;
        sh_r      <= prod[DRAW_LSB +: DRAW_W];
        rem_r     <= '0;
        dvs_r     <= {1'b0, bound} + (VALUE_W+1)'(1);
        cnt_r     <= '0;
        div_act_r <= !req.seed_op;
        done_r    <= req.seed_op;
      end else if (div_act_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[DRAW_W-2:0], 1'b0};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          div_act_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign state_out = st_r;
  assign rem_out   = rem_r[VALUE_W-1:0];

endmodule

// ===== src/lcg_random_with_shuffle_table.sv =====
// Every accepted item ends in an out_valid strobe: a seed or a bounded draw once the shared
// unit is done, a quick read after the table read, a shuffle after the fill and all swaps.
// busy stays high for the whole item, so one item is in flight at a time; the draw
// time is set by the shared multiply and 15-step restoring remainder unit.
// Reset (rst_n low, synchronous) sets the state to 1, the read index to 0 and marks
// the table as all zeros. Results are strobed for one cycle; the receiver cannot stall.
module lcg_random_with_shuffle_table
  import lcgrs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [VALUE_W-1:0] in_seed_value,
  input  logic [VALUE_W-1:0] in_upper_bound,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_value
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WAIT    = 4'd1;
  localparam logic [3:0] S_FILL    = 4'd2;
  localparam logic [3:0] S_SH_DRAW = 4'd3;
  localparam logic [3:0] S_SH_WAIT = 4'd4;
  localparam logic [3:0] S_RDI     = 4'd5;
  localparam logic [3:0] S_RDJ     = 4'd6;
  localparam logic [3:0] S_WRI     = 4'd7;
  localparam logic [3:0] S_WRJ     = 4'd8;
  localparam logic [3:0] S_QRD     = 4'd9;
  localparam logic [3:0] S_QOUT    = 4'd10;

  logic [3:0]         state_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [STATE_W-1:0] gen_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               filled_r;
  logic               seed_r;
  logic [IDX_W-1:0]   i_r;
  logic [IDX_W-1:0]   j_r;
  logic [BYTE_W-1:0]  t_r;

  logic               accept;
  unit_req_t          unit_req;
  unit_rsp_t          unit_rsp;
  logic [STATE_W-1:0] unit_operand;
  logic [VALUE_W-1:0] unit_bound;
  logic [STATE_W-1:0] unit_state;
  logic [VALUE_W-1:0] unit_rem;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Requests to the shared unit: seeds and draws from the ports, draws of the shuffle.
  always_comb begin
    unit_req.start   = (accept && (in_mode == MODE_SEED || in_mode == MODE_DRAW))
                       || (state_r == S_SH_DRAW);
    unit_req.seed_op = (state_r == S_IDLE) && (in_mode == MODE_SEED);
    unit_operand     = unit_req.seed_op ? {{(STATE_W-VALUE_W){1'b0}}, in_seed_value} : gen_r;
    unit_bound       = (state_r == S_SH_DRAW) ? VALUE_W'(i_r) : in_upper_bound;
  end

  lcgrs_draw u_draw (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (unit_req),
    .operand   (unit_operand),
    .bound     (unit_bound),
    .rsp       (unit_rsp),
    .state_out (unit_state),
    .rem_out   (unit_rem)
  );

  // Table port selection for the fill, the swap steps and the quick read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = BYTE_W'(i_r);
    ram_raddr = rd_idx_r;
    case (state_r)
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_RDI: begin
        ram_raddr = i_r;
      end
      S_RDJ: begin
        ram_raddr = j_r;
      end
      S_WRI: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = t_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lcgrs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= STATE_W'(1);
      rd_idx_r    <= '0;
      filled_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_SEED, MODE_DRAW: begin
                seed_r  <= (in_mode == MODE_SEED);
                state_r <= S_WAIT;
              end
              MODE_SHUF: begin
                // The fill writes every entry, so the table reads back from memory from now on.
                filled_r <= 1'b1;
                i_r      <= '0;
                state_r  <= S_FILL;
              end
              default: begin
                state_r <= S_QRD;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (unit_rsp.done) begin
            gen_r       <= unit_state;
            out_valid_r <= 1'b1;
            out_value_r <= seed_r ? '0 : unit_rem;
            state_r     <= S_IDLE;
          end
        end
        S_FILL: begin
          // Identity fill; the counter ends on the top entry, where the shuffle starts.
          if (i_r == IDX_LAST) begin
            state_r <= S_SH_DRAW;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
        end
        S_SH_DRAW: begin
          state_r <= S_SH_WAIT;
        end
        S_SH_WAIT: begin
          if (unit_rsp.done) begin
            gen_r   <= unit_state;
            j_r     <= unit_rem[IDX_W-1:0];
            state_r <= S_RDI;
          end
        end
        S_RDI: begin
          state_r <= S_RDJ;
        end
        S_RDJ: begin
          t_r     <= ram_rdata;
          state_r <= S_WRI;
        end
        S_WRI: begin
          state_r <= S_WRJ;
        end
        S_WRJ: begin
          if (i_r == IDX_W'(1)) begin
            rd_idx_r    <= '0;
            out_valid_r <= 1'b1;
            out_value_r <= '0;
            state_r     <= S_IDLE;
          end else begin
            i_r     <= i_r - IDX_W'(1);
            state_r <= S_SH_DRAW;
          end
        end
        S_QRD: begin
          state_r <= S_QOUT;
        end
        S_QOUT: begin
          out_valid_r <= 1'b1;
          out_value_r <= filled_r ? VALUE_W'(ram_rdata) : '0;
          rd_idx_r    <= (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + IDX_W'(1);
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // The shared unit only finishes while the sequencer waits for it.
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    unit_rsp.done |-> (state_r == S_WAIT || state_r == S_SH_WAIT))
    else $error("arithmetic unit finished while the sequencer was not waiting");

  // A result beat is strobed only as the sequencer returns to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobed while an item is still in progress");

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  // The read index stays inside the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= IDX_LAST)
    else $error("read index left the table");

endmodule
